>>> design/swbi_pkg.sv
`timescale 1ns / 1ps

package swbi_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 11;
  localparam int KCNT_W = 11;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(1024);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_INCR = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] operand_value;
    logic [KCNT_W-1:0]        bottom_count;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     was_empty;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_pending;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

>>> design/swbi_ctrl.sv
`timescale 1ns / 1ps

module swbi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  swbi_pkg::dp_status_t  status,
  output swbi_pkg::dp_cmd_t     cmd
);

  swbi_pkg::state_t state_r, state_nxt;
  logic can_commit;

  assign in_stall   = (state_r != swbi_pkg::ST_IDLE);
  // hold the write-back while a result has nowhere to go
  assign can_commit = !status.res_pending || !status.out_busy;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      swbi_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = swbi_pkg::ST_EXEC;
        end
      end
      swbi_pkg::ST_EXEC: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = swbi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swbi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swbi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/swbi_dp.sv
`timescale 1ns / 1ps

module swbi_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swbi_pkg::in_item_t            in_item,
  input  logic                          cfg_valid,
  input  logic [swbi_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output swbi_pkg::out_item_t           out_item,
  input  swbi_pkg::dp_cmd_t             cmd,
  output swbi_pkg::dp_status_t          status
);

  localparam int AW = swbi_pkg::ADDR_W;
  localparam int CW = swbi_pkg::CNT_W;
  localparam int DW = swbi_pkg::DATA_W;

  logic [DW-1:0] entry_mem [swbi_pkg::DEPTH];
  logic [DW-1:0] offset_mem [swbi_pkg::DEPTH];

  logic [CW-1:0]              count_r;
  logic [swbi_pkg::CFG_W-1:0] max_r;

  logic [1:0]    cmd_r;
  logic [DW-1:0] operand_r;
  logic [AW-1:0] addr_b_r;
  logic          push_ok_r, incr_hit_r, empty_r, carry_r;
  logic [DW-1:0] ent_rd_r, off_a_rd_r, off_b_rd_r;

  logic                out_valid_r;
  swbi_pkg::out_item_t out_item_r;

  // decode at acceptance
  logic [CW-1:0] n_clip, top;
  logic [AW-1:0] addr_a, addr_b;
  logic          is_pop_in;

  assign is_pop_in = (in_item.command == swbi_pkg::CMD_POP);
  assign n_clip    = (CW'(in_item.bottom_count) < count_r) ? CW'(in_item.bottom_count) : count_r;
  assign top       = count_r - CW'(1);
  assign addr_a    = top[AW-1:0];
  assign addr_b    = is_pop_in ? AW'(top - CW'(1)) : AW'(n_clip - CW'(1));

  // write-back
  logic          is_push, is_pop, is_incr;
  logic          ent_we, off_we;
  logic [AW-1:0] off_waddr;
  logic [DW-1:0] off_wdata, sum_b;

  assign is_push = (cmd_r == swbi_pkg::CMD_PUSH);
  assign is_pop  = (cmd_r == swbi_pkg::CMD_POP);
  assign is_incr = (cmd_r == swbi_pkg::CMD_INCR);

  assign sum_b     = off_b_rd_r + (is_pop ? off_a_rd_r : operand_r);
  assign ent_we    = cmd.commit && is_push && push_ok_r;
  // a push zeroes the offset slot it claims, so no clearing pass is needed
  assign off_we    = cmd.commit && ((is_push && push_ok_r) || (is_incr && incr_hit_r) ||
                                    (is_pop && !empty_r && carry_r));
  assign off_waddr = is_push ? count_r[AW-1:0] : addr_b_r;
  assign off_wdata = is_push ? '0 : sum_b;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[count_r[AW-1:0]] <= operand_r;
    end
    if (cmd.load) begin
      ent_rd_r <= entry_mem[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      offset_mem[off_waddr] <= off_wdata;
    end
    if (cmd.load) begin
      off_a_rd_r <= offset_mem[addr_a];
      off_b_rd_r <= offset_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_item.command;
      operand_r  <= in_item.operand_value;
      addr_b_r   <= addr_b;
      push_ok_r  <= (swbi_pkg::CFG_W'(count_r) < max_r) &&
                    (count_r < CW'(swbi_pkg::DEPTH));
      incr_hit_r <= (n_clip != '0);
      empty_r    <= (count_r == '0);
      carry_r    <= (count_r > CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= swbi_pkg::MAX_ENTRIES_RST;
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
      if (cmd.commit && is_push && push_ok_r) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.commit && is_pop && !empty_r) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && is_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_pop) begin
      out_item_r.popped_value <= empty_r ? '1 : (ent_rd_r + off_a_rd_r);
      out_item_r.was_empty    <= empty_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_item           = out_item_r;
  assign status.res_pending = is_pop;
  assign status.out_busy    = out_valid_r && out_stall;

endmodule

>>> design/stack_with_bulk_increment_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_item (command, operand_value, bottom_count)
// out     | output    | out_valid/out_stall| out_item (popped_value, was_empty)
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (max_entries)
//
// Every command reads the offset and entry memories in ST_IDLE as it is accepted,
// then adds and writes the offset back in ST_EXEC. A pop stays in ST_EXEC while the
// output register is occupied and stalled. Reset is synchronous; the offset memory
// needs no clearing pass, so items are taken from the first cycle after reset.
// cfg_ready is always high.

module stack_with_bulk_increment_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swbi_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output swbi_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swbi_pkg::CFG_W-1:0]  cfg_data
);

  swbi_pkg::dp_cmd_t    dp_cmd;
  swbi_pkg::dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  swbi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  swbi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

endmodule

>>> design/swbi_checker.sv
`timescale 1ns / 1ps

module swbi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input swbi_pkg::out_item_t out_item
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // one item at a time: a transfer in closes the input for the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a fresh result follows a transfer in
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching transfer in");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.was_empty |-> (out_item.popped_value == '1))
    else $error("empty pop does not give -1");

endmodule

bind stack_with_bulk_increment_top swbi_checker u_swbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> tb/sv/stack_scoreboard_pkg.sv
`timescale 1ns / 1ps

package stack_scoreboard_pkg;

  import swbi_pkg::*;

  // command code the block leaves unused
  localparam logic [1:0] CMD_SPARE = 2'd3;

  class stack_scoreboard;
    logic [DATA_W-1:0] words   [DEPTH];
    logic [DATA_W-1:0] offsets [DEPTH];
    int unsigned       level;
    logic [CFG_W-1:0]  limit;
    out_item_t         expected_pops [$];
    int unsigned       errors;
    int unsigned       commands;
    int unsigned       pops;
    int unsigned       empty_pops;
    int unsigned       dropped_pushes;
    int unsigned       drops_at_depth;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        words[i]   = '0;
        offsets[i] = '0;
      end
      level          = 0;
      limit          = MAX_ENTRIES_RST;
      errors         = 0;
      commands       = 0;
      pops           = 0;
      empty_pops     = 0;
      dropped_pushes = 0;
      drops_at_depth = 0;
    endfunction

    function int unsigned capacity();
      return (int'(limit) < DEPTH) ? int'(limit) : DEPTH;
    endfunction

    function void set_limit(logic [CFG_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned outstanding();
      return expected_pops.size();
    endfunction

    // apply one accepted transfer to the stack copy and queue any pop result
    function void note_command(in_item_t it);
      out_item_t   res;
      int unsigned n;
      int unsigned top;
      commands++;
      case (it.command)
        CMD_PUSH: begin
          if (level < capacity()) begin
            words[level] = it.operand_value;
            level++;
          end else begin
            dropped_pushes++;
            if (level == DEPTH) drops_at_depth++;
          end
        end
        CMD_INCR: begin
          n = (int'(it.bottom_count) < level) ? int'(it.bottom_count) : level;
          if (n > 0) offsets[n-1] = offsets[n-1] + it.operand_value;
        end
        CMD_POP: begin
          pops++;
          if (level == 0) begin
            res.popped_value = '1;
            res.was_empty    = 1'b1;
            empty_pops++;
          end else begin
            level--;
            top              = level;
            res.popped_value = words[top] + offsets[top];
            res.was_empty    = 1'b0;
            // carry the lazy offset down before clearing it
            if (top > 0) offsets[top-1] = offsets[top-1] + offsets[top];
            offsets[top] = '0;
          end
          expected_pops.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_pops.size() == 0) begin
        $error("result with no pop waiting: popped_value %0d was_empty %0b",
               got.popped_value, got.was_empty);
        errors++;
        return;
      end
      want = expected_pops.pop_front();
      if (got.popped_value !== want.popped_value) begin
        $error("popped_value: expected %0d, actual %0d", want.popped_value, got.popped_value);
        errors++;
      end
      if (got.was_empty !== want.was_empty) begin
        $error("was_empty: expected %0b, actual %0b", want.was_empty, got.was_empty);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import swbi_pkg::*;
  import stack_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 12;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  stack_scoreboard  sb;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      cycle_count   = 0;
  int unsigned      limit_writes  = 0;

  stack_with_bulk_increment_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t cmd(logic [1:0] c, logic [DATA_W-1:0] v,
                                   logic [KCNT_W-1:0] k);
    in_item_t it;
    it.command       = c;
    it.operand_value = v;
    it.bottom_count  = k;
    return it;
  endfunction

  function automatic in_item_t make_item(int unsigned push_w, int unsigned pop_w,
                                         int unsigned incr_w);
    in_item_t    it;
    int unsigned pick;
    int unsigned lvl;
    pick = $urandom_range(99);
    lvl  = sb.level;
    if (pick < push_w) it.command = CMD_PUSH;
    else if (pick < push_w + pop_w) it.command = CMD_POP;
    else if (pick < push_w + pop_w + incr_w) it.command = CMD_INCR;
    else it.command = CMD_SPARE;
    case ($urandom_range(7))
      0:       it.operand_value = 32'h7FFF_FFFF;
      1:       it.operand_value = 32'h8000_0000;
      2:       it.operand_value = 32'($urandom_range(8)) - 32'd4;
      default: it.operand_value = $urandom;
    endcase
    case ($urandom_range(5))
      0:       it.bottom_count = '0;
      1:       it.bottom_count = KCNT_W'(lvl);
      2:       it.bottom_count = KCNT_W'($urandom_range(lvl + 2));
      3:       it.bottom_count = KCNT_W'($urandom);
      default: it.bottom_count = KCNT_W'($urandom_range(1, (lvl > 0) ? lvl : 1));
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    // idling schedule follows the number of transfers so far
    if (sb.commands < 430) begin
      send_idle_pct = 11;
      recv_idle_pct = 72;
    end else if (sb.commands < 860) begin
      send_idle_pct = 72;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_command(it);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk);
    // pushes and increments give no result: let the last one retire
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    end_burst();
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(value);
    limit_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned push_w,
                           input int unsigned pop_w, input int unsigned incr_w);
    repeat (n) send_item(make_item(push_w, pop_w, incr_w));
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, extremes, clipping, unused code, full at limit one
    send_item(cmd(CMD_POP,   32'd0,         11'd0));
    send_item(cmd(CMD_INCR,  32'd9,         11'd5));
    send_item(cmd(CMD_PUSH,  32'h7FFF_FFFF, 11'd0));
    send_item(cmd(CMD_PUSH,  32'h8000_0000, 11'd2047));
    send_item(cmd(CMD_PUSH,  32'd0,         11'd0));
    send_item(cmd(CMD_PUSH,  32'hFFFF_FFFF, 11'd0));
    send_item(cmd(CMD_INCR,  32'd100,       11'd0));
    send_item(cmd(CMD_INCR,  32'd1,         11'd1));
    send_item(cmd(CMD_INCR,  32'h7FFF_FFFF, 11'd2047));
    send_item(cmd(CMD_INCR,  32'h8000_0000, 11'd3));
    send_item(cmd(CMD_SPARE, $urandom,      11'h7FF));
    send_item(cmd(CMD_INCR,  32'hFFFF_FFFF, 11'd1024));
    repeat (5) send_item(cmd(CMD_POP, 32'hFFFF_FFFF, 11'h7FF));
    write_limit(CFG_W'(1));
    send_item(cmd(CMD_PUSH,  32'h1234_5678, 11'd0));
    send_item(cmd(CMD_PUSH,  32'h0BAD_F00D, 11'd0));
    send_item(cmd(CMD_INCR,  32'h8000_0001, 11'd2047));
    send_item(cmd(CMD_POP,   32'd0,         11'd0));
    send_item(cmd(CMD_POP,   32'd0,         11'd0));

    write_limit(CFG_W'(8));
    run_phase(60, 40, 30, 25);
    write_limit(CFG_W'(1));
    run_phase(20, 40, 30, 25);
    write_limit(CFG_W'(0));
    run_phase(15, 40, 30, 25);
    // fill to the full depth with a limit that saturates
    write_limit(CFG_W'(2047));
    while (sb.drops_at_depth < 4) send_item(make_item(97, 0, 3));
    // limit now far below the count
    write_limit(CFG_W'(5));
    run_phase(50, 30, 50, 15);
    write_limit(CFG_W'($urandom_range(1, 2047)));
    run_phase(25, 35, 35, 25);
    write_limit(CFG_W'($urandom_range(1, 16)));
    run_phase(25, 30, 45, 20);
    end_burst();

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);

    $display("Ran %0d commands over %0d limit settings: %0d pops, %0d on an empty stack.",
             sb.commands, limit_writes + 1, sb.pops, sb.empty_pops);
    $display("Pushes dropped at the limit: %0d, of which %0d with the stack at full depth.",
             sb.dropped_pushes, sb.drops_at_depth);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
